FILE: rtl/core/dominance_memo_cache_core_defines.svh
// Assertion macros for the memo cache core.
// Included by files that carry concurrent assertions; no other dependency.
`ifndef DOMINANCE_MEMO_CACHE_CORE_DEFINES_SVH
`define DOMINANCE_MEMO_CACHE_CORE_DEFINES_SVH
`ifndef SYNTH
`define DMC_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("assert");
`define DMC_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("assert");
`else
`define DMC_ASSERT_IMP(label, clk, rst, a, c)
`define DMC_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

FILE: rtl/core/dmc_pkg.sv
// Shared constants for the memo cache core.
// No dependencies.
package dmc_pkg;
  localparam int SQUARES_DEF  = 64;
  localparam int WAYS_DEF     = 8;
  localparam int TAG_BITS_DEF = 64;
  localparam int MOVE_W       = 8;
  localparam int BOUND_W      = 10;
  localparam int BOUND_MAX    = 1023;
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;
endpackage

FILE: rtl/core/dmc_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module dmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/dmc_front.sv
// Front end: accepts requests, forms the line index, pushes into a 2-deep queue.
// Depends on dmc_pkg.
module dmc_front #(
  parameter int SQUARES  = dmc_pkg::SQUARES_DEF,
  parameter int TAG_BITS = dmc_pkg::TAG_BITS_DEF,
  parameter int LINE_W   = 2 * $clog2(SQUARES),
  parameter int QW       = 1 + LINE_W + 2 * dmc_pkg::MOVE_W + 2 * TAG_BITS + dmc_pkg::BOUND_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          req_type,
  input  logic [5:0]    square_a,
  input  logic [7:0]    moves_a,
  input  logic [63:0]   state_a,
  input  logic [5:0]    square_b,
  input  logic [7:0]    moves_b,
  input  logic [63:0]   state_b,
  input  logic [9:0]    bound_in,
  output logic          q_valid,
  input  logic          q_pop,
  output logic [QW-1:0] q_data
);
  localparam int SQ_W = $clog2(SQUARES);
  logic [QW-1:0] slot [2];
  logic          rd_ptr, wr_ptr;
  logic [1:0]    count;
  logic [SQ_W-1:0] sa, sb;
  logic push;

  // modulo by a power of two (range is a power of two here)
  assign sa = SQ_W'(32'(square_a) % SQUARES);
  assign sb = SQ_W'(32'(square_b) % SQUARES);
  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (count != 2'd0);
  assign q_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= {req_type, sa, sb, moves_a, moves_b,
                               state_a[TAG_BITS-1:0], state_b[TAG_BITS-1:0], bound_in};
    if (rst) begin
      rd_ptr <= 1'b0; wr_ptr <= 1'b0; count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end
endmodule

FILE: rtl/core/dmc_back.sv
// Back end: reads a line, compares all ways, writes back, emits one result.
// Depends on dmc_pkg, dmc_ram and the assertion header.
`include "dominance_memo_cache_core_defines.svh"
module dmc_back #(
  parameter int SQUARES  = dmc_pkg::SQUARES_DEF,
  parameter int WAYS     = dmc_pkg::WAYS_DEF,
  parameter int TAG_BITS = dmc_pkg::TAG_BITS_DEF,
  parameter int LINE_W   = 2 * $clog2(SQUARES),
  parameter int QW       = 1 + LINE_W + 2 * dmc_pkg::MOVE_W + 2 * TAG_BITS + dmc_pkg::BOUND_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_pop,
  input  logic [QW-1:0] q_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          found,
  output logic [9:0]    bound_out
);
  // line index is {square_a, square_b}, so the store spans the full index space
  localparam int LINES = 1 << LINE_W;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CW    = 2 * dmc_pkg::MOVE_W + dmc_pkg::BOUND_W;
  localparam int EW    = 2 * TAG_BITS + CW;
  localparam int RW    = WAYS * EW;
  localparam int CLR_LAST = LINES - 1;
  localparam logic [1:0] S_CLEAR = 2'd0, S_IDLE = 2'd1, S_CMP = 2'd2, S_OUT = 2'd3;

  logic [1:0] state;
  logic [LINE_W-1:0] clr_addr;
  logic [QW-1:0] req;
  logic [WAY_W-1:0] victim;
  logic r_type;
  logic [LINE_W-1:0] r_line;
  logic [7:0] r_ma, r_mb;
  logic [TAG_BITS-1:0] r_ta, r_tb;
  logic [9:0] r_bound;
  assign {r_type, r_line, r_ma, r_mb, r_ta, r_tb, r_bound} = req;

  // Line store: valid bits and all ways of a line in one row each.
  logic v_we, d_we;
  logic [LINE_W-1:0] v_waddr;
  logic [WAYS-1:0] v_wdata, v_rdata;
  logic [RW-1:0] d_wdata, d_rdata;
  logic [WAY_W-1:0] wr_way;

  dmc_ram #(.WIDTH(WAYS), .DEPTH(LINES)) u_valid (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(q_data[QW-2 -: LINE_W]), .rdata(v_rdata));
  dmc_ram #(.WIDTH(RW), .DEPTH(LINES)) u_data (
    .clk(clk), .we(d_we), .waddr(r_line), .wdata(d_wdata),
    .raddr(q_data[QW-2 -: LINE_W]), .rdata(d_rdata));

  // Per-way compare, all ways in parallel.
  logic [WAYS-1:0] match, dom_req, dom_way, inval;
  logic [WAYS-1:0][10:0] sums;
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      logic [EW-1:0] e;
      logic [7:0] cma, cmb;
      logic [9:0] creq;
      e = d_rdata[w*EW +: EW];
      {cma, cmb, creq} = e[CW-1:0];
      match[w]   = v_rdata[w] && e[EW-1 -: TAG_BITS] == r_ta &&
                   e[CW +: TAG_BITS] == r_tb;
      dom_req[w] = match[w] && r_ma >= cma && r_mb >= cmb;
      dom_way[w] = match[w] && r_ma <= cma && r_mb <= cmb;
      inval[w]   = !v_rdata[w];
      sums[w]    = 11'(creq) + 11'(r_ma - cma) + 11'(r_mb - cmb);
    end
  end

  // Lookup: first hit before the first invalid way; other ways are skipped.
  // Insert: first way that drops the request or takes it, else the victim way.
  logic l_hit;
  logic [10:0] l_sum;
  logic i_drop, i_write;
  always_comb begin
    logic l_stop, i_stop;
    l_hit = 1'b0; l_sum = '0; l_stop = 1'b0; i_stop = 1'b0;
    i_drop = 1'b0; i_write = 1'b0; wr_way = victim;
    for (int w = 0; w < WAYS; w++) begin
      if (!l_stop) begin
        if (inval[w]) begin
          l_stop = 1'b1;
        end else if (dom_req[w]) begin
          l_stop = 1'b1; l_hit = 1'b1; l_sum = sums[w];
        end
      end
      if (!i_stop) begin
        if (dom_req[w]) begin
          i_stop = 1'b1; i_drop = 1'b1;
        end else if (inval[w] || dom_way[w]) begin
          i_stop = 1'b1; i_write = 1'b1; wr_way = WAY_W'(w);
        end
      end
    end
  end

  logic [9:0] l_sat, l_res;
  assign l_sat = (l_sum > 11'(dmc_pkg::BOUND_MAX)) ? 10'(dmc_pkg::BOUND_MAX) : l_sum[9:0];
  assign l_res = (l_hit && l_sat < r_bound) ? l_sat : r_bound;

  logic do_ins, full;
  assign do_ins = (state == S_CMP) && (r_type == dmc_pkg::REQ_INSERT) && !i_drop;
  assign full = !i_write;

  always_comb begin
    d_wdata = d_rdata;
    d_wdata[wr_way*EW +: EW] = {r_ta, r_tb, r_ma, r_mb, r_bound};
    v_wdata = v_rdata;
    v_wdata[wr_way] = 1'b1;
    if (state == S_CLEAR) v_wdata = '0;
  end
  assign d_we = do_ins;
  assign v_we = do_ins || (state == S_CLEAR);
  assign v_waddr = (state == S_CLEAR) ? clr_addr : r_line;
  assign q_pop = (state == S_IDLE) && q_valid;
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (q_pop) req <= q_data;
    if (state == S_CMP) begin
      found <= (r_type == dmc_pkg::REQ_LOOKUP) && l_hit;
      bound_out <= (r_type == dmc_pkg::REQ_LOOKUP) ? l_res : r_bound;
    end
    if (rst) begin
      state <= S_CLEAR; clr_addr <= '0; victim <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LINE_W'(CLR_LAST)) state <= S_IDLE;
        end
        S_IDLE: if (q_valid) state <= S_CMP;
        S_CMP: begin
          if (do_ins && full)
            victim <= (victim == WAY_W'(WAYS - 1)) ? '0 : victim + 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `DMC_ASSERT_IMP(a_pop_idle, clk, rst, q_pop, state == S_IDLE)
  `DMC_ASSERT_NXT(a_cmp_out, clk, rst, state == S_CMP, state == S_OUT)
  `DMC_ASSERT_IMP(a_ins_found, clk, rst, out_valid && r_type == dmc_pkg::REQ_INSERT, !found)
  `DMC_ASSERT_IMP(a_no_wr_clear, clk, rst, d_we, state == S_CMP)
endmodule

FILE: rtl/core/dominance_memo_cache_core.sv
// Top level of the dominance memo cache.
// Depends on dmc_pkg, dmc_front, dmc_back (and through it dmc_ram).
//
// Usage:
//  Input channel (in_valid/in_ready) carries one request transaction:
//  req_type selects insert or lookup; square_a/square_b pick the line.
//  Output channel (out_valid/out_ready) returns one result transaction per
//  request, in order: found and bound_out.
//  When idle, an accepted request passes the queue, then the pop with line read,
//  then compare/write-back into the result register, before out_valid.
//  The back end takes one request at a time (pop, compare/write-back, result),
//  set by the single line read then write-back of the back end;
//  the read-modify-write of one line finishes before the next read.
//  A two-entry queue parts the front from the back, so up to two requests
//  are taken while a result waits.
//  Reset: the valid store is swept, one line a cycle, all 2**(2*clog2(SQUARES))
//  lines (4096 by default); requests queue meanwhile, at most two.
//  If the receiver stalls, the result holds and the queue fills, then
//  in_ready drops.
module dominance_memo_cache_core #(
  parameter int SQUARES  = dmc_pkg::SQUARES_DEF,
  parameter int WAYS     = dmc_pkg::WAYS_DEF,
  parameter int TAG_BITS = dmc_pkg::TAG_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [5:0]  square_a,
  input  logic [7:0]  moves_a,
  input  logic [63:0] state_a,
  input  logic [5:0]  square_b,
  input  logic [7:0]  moves_b,
  input  logic [63:0] state_b,
  input  logic [9:0]  bound_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [9:0]  bound_out
);
  localparam int LINE_W = 2 * $clog2(SQUARES);
  localparam int QW = 1 + LINE_W + 2 * dmc_pkg::MOVE_W + 2 * TAG_BITS + dmc_pkg::BOUND_W;

  logic q_valid, q_pop;
  logic [QW-1:0] q_data;

  dmc_front #(.SQUARES(SQUARES), .TAG_BITS(TAG_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .square_a(square_a), .moves_a(moves_a), .state_a(state_a),
    .square_b(square_b), .moves_b(moves_b), .state_b(state_b), .bound_in(bound_in),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data));

  dmc_back #(.SQUARES(SQUARES), .WAYS(WAYS), .TAG_BITS(TAG_BITS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .out_valid(out_valid), .out_ready(out_ready), .found(found), .bound_out(bound_out));
endmodule
